/* sv/ps2_keyboard_device_link_defines.svh */
// ---------------------------------------------------------------------------
// assertion macros for the ps2 keyboard device link
// ---------------------------------------------------------------------------
`ifndef PS2_KEYBOARD_DEVICE_LINK_DEFINES_SVH
`define PS2_KEYBOARD_DEVICE_LINK_DEFINES_SVH
`ifndef SYNTHESIS
`define PKD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("pkd check failed");
`define PKD_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("pkd reset check failed");
`else
`define PKD_ASSERT(lbl, prop)
`define PKD_ASSERT_RST(lbl, prop)
`endif
`endif

/* sv/pkd_pkg.sv */
// ---------------------------------------------------------------------------
// pkd_pkg
// types and constants shared by the ps2 keyboard device link
// ---------------------------------------------------------------------------
package pkd_pkg;
    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int REPEAT_DEPTH_DEF = 10;

    localparam logic [1:0] CMD_HOST = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_PUSH = 2'd2;

    localparam logic [2:0] PK_DATA  = 3'd0;
    localparam logic [2:0] PK_START = 3'd1;
    localparam logic [2:0] PK_END   = 3'd2;
    localparam logic [2:0] PK_NOREP = 3'd3;
    localparam logic [2:0] PK_SPLIT = 3'd4;
    localparam logic [2:0] PK_STOP  = 3'd5;

    localparam logic [7:0] B_ACK   = 8'hFA;
    localparam logic [7:0] B_BAT   = 8'hAA;
    localparam logic [7:0] B_ID0   = 8'hAB;
    localparam logic [7:0] B_ID1   = 8'h83;
    localparam logic [7:0] B_RSND  = 8'hFE;
    localparam logic [7:0] B_ECHO  = 8'hEE;
    localparam logic [7:0] B_TYPM  = 8'hF3;
    localparam logic [7:0] B_LEDS  = 8'hED;
    localparam logic [7:0] B_SCAN  = 8'hF0;
    localparam logic [7:0] B_DEF   = 8'hF6;
    localparam logic [7:0] B_RDID  = 8'hF2;
    localparam logic [7:0] B_RESET = 8'hFF;
    localparam logic [7:0] B_SET2  = 8'h02;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] host_byte;
        logic [2:0] push_kind;
        logic [7:0] push_byte;
    } pkd_in_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       scan_request;
        logic       scan_clear;
        logic       led_valid;
        logic [2:0] led_bits;
        logic       led_init;
    } pkd_out_t;
endpackage

/* sv/pkd_front.sv */
// ---------------------------------------------------------------------------
// pkd_front
// input skid register: accepts words and holds one for the engine
// ---------------------------------------------------------------------------
module pkd_front
    import pkd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  pkd_in_t in_word,
    output logic    q_valid,
    input  logic    q_take,
    output pkd_in_t q_word
);
    logic    full_reg;
    pkd_in_t word_reg;

    assign in_stall = full_reg && !q_take;
    assign q_valid  = full_reg;
    assign q_word   = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (!in_stall)
            full_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            word_reg <= in_word;
    end
endmodule

/* sv/pkd_engine.sv */
// ---------------------------------------------------------------------------
// pkd_engine
// command machine, scan queue and typematic repeat; while res_stall is low, one word per cycle
// ---------------------------------------------------------------------------
`include "ps2_keyboard_device_link_defines.svh"
module pkd_engine
    import pkd_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int REPEAT_DEPTH = REPEAT_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     q_valid,
    output logic     q_take,
    input  pkd_in_t  q_word,
    output logic     res_valid,
    input  logic     res_stall,
    output pkd_out_t res_word
);
    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int RW = $clog2(REPEAT_DEPTH + 1);

    typedef enum logic [3:0] {
        M_NORMAL, M_REPEAT, M_WAIT_RESET, M_WAIT_ID, M_WAIT_ID1,
        M_SCAN_SET, M_SCAN_REPLY, M_AUTOREP, M_LEDS
    } mode_t;

    mode_t      mode_reg, mode_next;
    logic [8:0] qmem [QUEUE_DEPTH];
    logic [7:0] rbuf [REPEAT_DEPTH];
    logic [QW-1:0] head_reg, head_next, tail_reg, tail_next, tail_inc, head_inc;
    logic       rec_reg, rec_next;
    logic [RW-1:0] rlen_reg, rlen_next, rpos_reg, rpos_next, rp;
    logic [9:0] tick_reg, tick_next;
    logic [1:0] delay_reg, delay_next;
    logic [5:0] rate_reg, rate_next;
    logic [7:0] last_reg, last_next;
    logic [2:0] leds_reg, leds_next;
    logic       qwr, rwr;
    logic [8:0] qwr_data;
    logic [8:0] qhead_data;
    logic [9:0] rep_mod;
    logic       ovalid_reg;
    pkd_out_t   out_reg, o;
    logic       snd;
    logic [7:0] sb;
    logic       busy;

    assign q_take    = q_valid && !(ovalid_reg && res_stall);
    assign res_valid = ovalid_reg;
    assign res_word  = out_reg;
    assign busy      = 1'b0;

    always_comb
    begin
        tail_inc = (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        head_inc = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    end
    assign qhead_data = qmem[head_inc];
    assign rep_mod    = 10'd3 + 10'(rate_reg) * 10'd10;

    always_comb
    begin
        mode_next = mode_reg; head_next = head_reg; tail_next = tail_reg;
        rec_next = rec_reg; rlen_next = rlen_reg; rpos_next = rpos_reg;
        tick_next = tick_reg; delay_next = delay_reg; rate_next = rate_reg;
        last_next = last_reg; leds_next = leds_reg;
        qwr = 1'b0; qwr_data = '0; rwr = 1'b0; rp = rpos_reg;
        snd = 1'b0; sb = '0;
        o = '0;
        case (q_word.command)
            CMD_HOST:
            begin
                snd = 1'b1; sb = B_ACK;
                unique case (mode_reg)
                    M_SCAN_SET:
                    begin
                        head_next = '0; tail_next = '0; rlen_next = '0;
                        rpos_next = '0; tick_next = '0; o.scan_clear = 1'b1;
                        mode_next = (q_word.host_byte == 8'd0) ? M_SCAN_REPLY : M_NORMAL;
                    end
                    M_AUTOREP:
                    begin
                        delay_next = q_word.host_byte[6:5];
                        rate_next  = 6'({3'b000, q_word.host_byte[2:0]} << q_word.host_byte[4:3]);
                        mode_next  = M_NORMAL;
                    end
                    M_LEDS:
                    begin
                        leds_next = q_word.host_byte[2:0];
                        o.led_valid = 1'b1;
                        mode_next = M_NORMAL;
                    end
                    default:
                    begin
                        unique case (q_word.host_byte)
                            B_ECHO:  sb = B_ECHO;
                            B_RDID:  mode_next = M_WAIT_ID;
                            B_RESET: mode_next = M_WAIT_RESET;
                            B_RSND:  sb = last_reg;
                            B_SCAN:  mode_next = M_SCAN_SET;
                            B_LEDS:  mode_next = M_LEDS;
                            B_TYPM:  mode_next = M_AUTOREP;
                            B_DEF:
                            begin
                                delay_next = 2'd1; rate_next = 6'd5;
                                head_next = '0; tail_next = '0; rlen_next = '0;
                                rpos_next = '0; tick_next = '0; o.scan_clear = 1'b1;
                                mode_next = M_NORMAL;
                            end
                            default: mode_next = M_NORMAL;
                        endcase
                    end
                endcase
            end
            CMD_TICK:
            begin
                unique case (mode_reg)
                    M_NORMAL:
                    begin
                        if (head_reg == tail_reg)
                        begin
                            o.scan_request = 1'b1;
                            if (rlen_reg != '0)
                            begin
                                tick_next = tick_reg + 1'b1;
                                if (11'(tick_next) >= 11'(delay_reg) * 11'd50 + 11'd100)
                                begin
                                    tick_next = '0; rpos_next = '0; mode_next = M_REPEAT;
                                end
                            end
                        end
                        else
                        begin
                            head_next = head_inc;
                            if (!qhead_data[8])
                            begin
                                snd = 1'b1; sb = qhead_data[7:0]; tick_next = '0;
                            end
                        end
                    end
                    M_REPEAT:
                    begin
                        if (rpos_reg == '0)
                            o.scan_request = 1'b1;
                        if (rlen_reg == '0 || head_reg != tail_reg)
                        begin
                            mode_next = M_NORMAL; tick_next = '0;
                        end
                        else
                        begin
                            if (rpos_reg >= rlen_reg || rpos_reg >= RW'(REPEAT_DEPTH))
                                rp = '0;
                            rpos_next = rp;
                            if (tick_reg == 10'd1 || rp != '0)
                            begin
                                snd = 1'b1;
                                sb = rbuf[rp[$clog2(REPEAT_DEPTH)-1:0]];
                                rpos_next = (rp + 1'b1 >= rlen_reg) ? '0 : rp + 1'b1;
                            end
                            tick_next = (tick_reg + 1'b1 >= rep_mod) ? '0 : tick_reg + 1'b1;
                        end
                    end
                    M_SCAN_REPLY: begin snd = 1'b1; sb = B_SET2; mode_next = M_NORMAL; end
                    M_WAIT_ID:    begin snd = 1'b1; sb = B_ID0; mode_next = M_WAIT_ID1; end
                    M_WAIT_ID1:   begin snd = 1'b1; sb = B_ID1; mode_next = M_NORMAL; end
                    M_WAIT_RESET:
                    begin
                        head_next = '0; tail_next = '0; rlen_next = '0;
                        rpos_next = '0; tick_next = '0; o.scan_clear = 1'b1;
                        o.led_init = 1'b1; snd = 1'b1; sb = B_BAT; mode_next = M_NORMAL;
                    end
                    default: ;
                endcase
            end
            CMD_PUSH:
            begin
                case (q_word.push_kind)
                    PK_DATA:
                    begin
                        if (rec_reg && rlen_reg < RW'(REPEAT_DEPTH))
                        begin
                            rwr = 1'b1; rlen_next = rlen_reg + 1'b1;
                        end
                        if (tail_inc != head_reg)
                        begin
                            qwr = 1'b1; qwr_data = {1'b0, q_word.push_byte}; tail_next = tail_inc;
                        end
                    end
                    PK_START: begin rlen_next = '0; rec_next = 1'b1; end
                    PK_END:   rec_next = 1'b0;
                    PK_NOREP: begin rlen_next = '0; rec_next = 1'b0; end
                    PK_SPLIT:
                    begin
                        if (tail_inc != head_reg)
                        begin
                            qwr = 1'b1; qwr_data = 9'h100; tail_next = tail_inc;
                        end
                    end
                    PK_STOP:  rlen_next = '0;
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (snd)
        begin
            o.tx_valid = 1'b1; o.tx_byte = sb;
            if (sb != B_RSND)
                last_next = sb;
        end
        o.led_bits = leds_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_WAIT_RESET; head_reg <= '0; tail_reg <= '0; rec_reg <= 1'b0;
            rlen_reg <= '0; rpos_reg <= '0; tick_reg <= '0; delay_reg <= 2'd2;
            rate_reg <= 6'd10; last_reg <= '0; leds_reg <= '0; ovalid_reg <= 1'b0;
        end
        else
        begin
            if (!(ovalid_reg && res_stall))
                ovalid_reg <= q_valid && !busy;
            if (q_take)
            begin
                mode_reg <= mode_next; head_reg <= head_next; tail_reg <= tail_next;
                rec_reg <= rec_next; rlen_reg <= rlen_next; rpos_reg <= rpos_next;
                tick_reg <= tick_next; delay_reg <= delay_next; rate_reg <= rate_next;
                last_reg <= last_next; leds_reg <= leds_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
            out_reg <= o;
        if (q_take && qwr)
            qmem[tail_inc] <= qwr_data;
        if (q_take && rwr)
            rbuf[rlen_reg[$clog2(REPEAT_DEPTH)-1:0]] <= q_word.push_byte;
    end

    `PKD_ASSERT(a_rlen_bound, rlen_reg <= RW'(REPEAT_DEPTH))
    `PKD_ASSERT(a_out_hold, ovalid_reg && res_stall |=> ovalid_reg && $stable(out_reg))
    `PKD_ASSERT(a_clear_empty, q_take && o.scan_clear |=> head_reg == tail_reg && rlen_reg == '0)
    `PKD_ASSERT_RST(a_reset_mode, !rst_n |=> mode_reg == M_WAIT_RESET || rst_n)
endmodule

/* sv/ps2_keyboard_device_link.sv */
// ---------------------------------------------------------------------------
// ps2_keyboard_device_link
// device side of a ps2 keyboard link: commands, scan queue, typematic
// ---------------------------------------------------------------------------
// in channel: in_valid / in_stall carry one word: a host byte, a
// transmitter tick or a scanner push. out channel: out_valid / out_stall
// return exactly one result word per input word.
// path: an accepted input word passes the skid register, then the engine's
// output register, which drives out_valid and out_word. throughput: one
// word per cycle while out_stall is low, set by the command engine.
// reset (rst_n low) puts the machine in its wait-reset mode with empty
// queue and repeat buffer; the next tick sends the self-test byte.
// when out_stall is high while out_valid is high, the result holds and the engine
// takes no word, so in_stall is high while the skid register holds a word.
// ---------------------------------------------------------------------------
module ps2_keyboard_device_link
    import pkd_pkg::*;
#(
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int REPEAT_DEPTH = REPEAT_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  pkd_in_t  in_word,
    output logic     out_valid,
    input  logic     out_stall,
    output pkd_out_t out_word
);
    logic    q_valid, q_take;
    pkd_in_t q_word;

    pkd_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_word,
        .q_valid, .q_take, .q_word
    );

    pkd_engine #(.QUEUE_DEPTH(QUEUE_DEPTH), .REPEAT_DEPTH(REPEAT_DEPTH)) u_engine (
        .clk, .rst_n, .q_valid, .q_take, .q_word,
        .res_valid(out_valid), .res_stall(out_stall), .res_word(out_word)
    );
endmodule

/* bench/ps2_link_checker.sv */
// ---------------------------------------------------------------------------
// ps2 link checker
// watches both channels of the ps2 keyboard device link, predicts every
// result word from the accepted input words and compares field by field
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module ps2_link_checker
    import pkd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_stall,
    input  pkd_in_t  in_word,
    input  logic     out_valid,
    input  logic     out_stall,
    input  pkd_out_t out_word,
    output int       fail_count,
    output int       pending_words
);
    typedef enum logic [3:0] {
        MD_NORMAL, MD_REPEAT, MD_WAIT_RESET, MD_WAIT_ID, MD_WAIT_ID1,
        MD_SCAN_SET, MD_SCAN_REPLY, MD_AUTOREP, MD_LEDS
    } link_mode_t;

    localparam int QD = QUEUE_DEPTH_DEF;
    localparam int RD = REPEAT_DEPTH_DEF;

    link_mode_t mode;
    logic [8:0] scan_q [QD];
    int         q_head, q_tail;
    logic       recording;
    logic [7:0] rep_buf [RD];
    int         rep_len, rep_pos;
    int         ticks;
    int         delay_sel, rate;
    logic [7:0] last_sent;
    logic [2:0] leds;
    pkd_out_t   expected_words [$];

    assign pending_words = expected_words.size();

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    task automatic send(inout pkd_out_t r, input logic [7:0] b, input link_mode_t nm);
        if (b != B_RSND)
            last_sent = b;
        r.tx_valid = 1'b1;
        r.tx_byte  = b;
        mode       = nm;
    endtask

    task automatic clear_buffers(inout pkd_out_t r);
        q_head = 0;
        q_tail = 0;
        rep_len = 0;
        rep_pos = 0;
        ticks = 0;
        r.scan_clear = 1'b1;
    endtask

    task automatic queue_put(input logic [8:0] e);
        int nt;
        nt = (q_tail + 1) % QD;
        if (nt != q_head)
        begin
            q_tail = nt;
            scan_q[nt] = e;
        end
    endtask

    task automatic host_byte_in(inout pkd_out_t r, input logic [7:0] b);
        if (mode == MD_SCAN_SET)
        begin
            clear_buffers(r);
            send(r, B_ACK, b == 8'd0 ? MD_SCAN_REPLY : MD_NORMAL);
        end
        else if (mode == MD_AUTOREP)
        begin
            delay_sel = b[6:5];
            rate = (int'(b[2:0]) << b[4:3]) & 63;
            send(r, B_ACK, MD_NORMAL);
        end
        else if (mode == MD_LEDS)
        begin
            leds = b[2:0];
            r.led_valid = 1'b1;
            send(r, B_ACK, MD_NORMAL);
        end
        else
            case (b)
                B_ECHO:  send(r, B_ECHO, mode);
                B_RDID:  send(r, B_ACK, MD_WAIT_ID);
                B_RESET: send(r, B_ACK, MD_WAIT_RESET);
                B_RSND:  send(r, last_sent, mode);
                B_SCAN:  send(r, B_ACK, MD_SCAN_SET);
                B_LEDS:  send(r, B_ACK, MD_LEDS);
                B_TYPM:  send(r, B_ACK, MD_AUTOREP);
                B_DEF:
                begin
                    delay_sel = 1;
                    rate = 5;
                    clear_buffers(r);
                    send(r, B_ACK, MD_NORMAL);
                end
                default: send(r, B_ACK, MD_NORMAL);
            endcase
    endtask

    task automatic tick_in(inout pkd_out_t r);
        logic [8:0] e;
        case (mode)
            MD_NORMAL:
                if (q_head == q_tail)
                begin
                    r.scan_request = 1'b1;
                    if (rep_len > 0)
                    begin
                        ticks = (ticks + 1) & 1023;
                        if (ticks >= delay_sel * 50 + 100)
                        begin
                            ticks = 0;
                            rep_pos = 0;
                            mode = MD_REPEAT;
                        end
                    end
                end
                else
                begin
                    q_head = (q_head + 1) % QD;
                    e = scan_q[q_head];
                    if (!e[8])
                    begin
                        send(r, e[7:0], MD_NORMAL);
                        ticks = 0;
                    end
                end
            MD_REPEAT:
            begin
                if (rep_pos == 0)
                    r.scan_request = 1'b1;
                if (rep_len == 0 || q_head != q_tail)
                begin
                    mode = MD_NORMAL;
                    ticks = 0;
                end
                else
                begin
                    if (rep_pos >= rep_len || rep_pos >= RD)
                        rep_pos = 0;
                    if (ticks == 1 || rep_pos != 0)
                    begin
                        send(r, rep_buf[rep_pos], MD_REPEAT);
                        rep_pos++;
                        if (rep_pos >= rep_len)
                            rep_pos = 0;
                    end
                    ticks = (ticks + 1) % (3 + rate * 10);
                end
            end
            MD_SCAN_REPLY: send(r, B_SET2, MD_NORMAL);
            MD_WAIT_ID:    send(r, B_ID0, MD_WAIT_ID1);
            MD_WAIT_ID1:   send(r, B_ID1, MD_NORMAL);
            MD_WAIT_RESET:
            begin
                clear_buffers(r);
                r.led_init = 1'b1;
                send(r, B_BAT, MD_NORMAL);
            end
            default: ;
        endcase
    endtask

    task automatic push_in(input logic [2:0] kind, input logic [7:0] b);
        case (kind)
            PK_DATA:
            begin
                if (recording && rep_len < RD)
                begin
                    rep_buf[rep_len] = b;
                    rep_len++;
                end
                queue_put({1'b0, b});
            end
            PK_START: begin rep_len = 0; recording = 1'b1; end
            PK_END:   recording = 1'b0;
            PK_NOREP: begin rep_len = 0; recording = 1'b0; end
            PK_SPLIT: queue_put(9'h100);
            PK_STOP:  rep_len = 0;
            default: ;
        endcase
    endtask

    task automatic predict_word(input pkd_in_t w);
        pkd_out_t r;
        r = '0;
        if (w.command == CMD_HOST)
            host_byte_in(r, w.host_byte);
        else if (w.command == CMD_TICK)
            tick_in(r);
        else if (w.command == CMD_PUSH)
            push_in(w.push_kind, w.push_byte);
        r.led_bits = leds;
        expected_words.push_back(r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pkd_out_t want;
        if (!rst_n)
        begin
            mode = MD_WAIT_RESET;
            q_head = 0;
            q_tail = 0;
            recording = 1'b0;
            rep_len = 0;
            rep_pos = 0;
            ticks = 0;
            delay_sel = 2;
            rate = 10;
            last_sent = 8'd0;
            leds = 3'd0;
            fail_count = 0;
            expected_words.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_words.size() == 0)
                    report("unexpected word", out_word, 0);
                else
                begin
                    want = expected_words.pop_front();
                    if (out_word.tx_valid !== want.tx_valid)
                        report("tx_valid", out_word.tx_valid, want.tx_valid);
                    if (out_word.tx_byte !== want.tx_byte)
                        report("tx_byte", out_word.tx_byte, want.tx_byte);
                    if (out_word.scan_request !== want.scan_request)
                        report("scan_request", out_word.scan_request, want.scan_request);
                    if (out_word.scan_clear !== want.scan_clear)
                        report("scan_clear", out_word.scan_clear, want.scan_clear);
                    if (out_word.led_valid !== want.led_valid)
                        report("led_valid", out_word.led_valid, want.led_valid);
                    if (out_word.led_bits !== want.led_bits)
                        report("led_bits", out_word.led_bits, want.led_bits);
                    if (out_word.led_init !== want.led_init)
                        report("led_init", out_word.led_init, want.led_init);
                end
            end
            if (in_valid && !in_stall)
                predict_word(in_word);
        end
    end
endmodule

/* bench/testbench.sv */
// ---------------------------------------------------------------------------
// ps2 keyboard device link testbench
// drives host bytes, transmitter ticks and scanner pushes with random
// gaps and output stalls; the checker predicts and compares every result
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import pkd_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_stall;
    pkd_in_t  in_word;
    logic     out_valid;
    logic     out_stall;
    pkd_out_t out_word;
    int       fail_count;
    int       pending_words;
    int       idle_cycles;
    int       cycles;
    logic     no_gaps;

    ps2_keyboard_device_link uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
    );

    ps2_link_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .fail_count(fail_count), .pending_words(pending_words)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver stalls at random except during the no-gap stretch
    always @(posedge clk)
        out_stall <= !no_gaps && ($urandom_range(99) < 38);

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic [7:0] hb,
                             input logic [2:0] pk, input logic [7:0] pb);
        pkd_in_t w;
        w.command = cmd;
        w.host_byte = hb;
        w.push_kind = pk;
        w.push_byte = pb;
        while (!no_gaps && $urandom_range(99) < 38)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic host(input logic [7:0] b);
        send_word(CMD_HOST, b, 3'($urandom), 8'($urandom));
    endtask

    task automatic tick();
        send_word(CMD_TICK, 8'($urandom), 3'($urandom), 8'($urandom));
    endtask

    task automatic push(input logic [2:0] k, input logic [7:0] b);
        send_word(CMD_PUSH, 8'($urandom), k, b);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_words != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // a make sequence, its repeat wait and its release
    task automatic key_sequence();
        int n;
        int reps;
        n = $urandom_range(1, 12);
        reps = $urandom_range(2, 40);
        if ($urandom_range(3) != 0)
            push(PK_START, 8'd0);
        for (int i = 0; i < n; i++)
            if ($urandom_range(7) == 0)
                push(PK_SPLIT, 8'd0);
            else
                push(PK_DATA, 8'($urandom));
        if ($urandom_range(1))
            push(PK_END, 8'd0);
        for (int i = 0; i < reps; i++)
            tick();
        case ($urandom_range(3))
            0: push(PK_NOREP, 8'd0);
            1: push(PK_STOP, 8'd0);
            default: push(PK_DATA, 8'($urandom));
        endcase
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(99);
        if (r < 20)
            case ($urandom_range(9))
                0: host(B_ECHO);
                1: host(B_RDID);
                2: host(B_RESET);
                3: host(B_RSND);
                4: begin host(B_SCAN); host($urandom_range(1) ? 8'd0 : 8'($urandom)); end
                5: begin host(B_LEDS); host(8'($urandom)); end
                6: begin host(B_TYPM); host(8'($urandom_range(255)) & 8'h9F); end
                7: host(B_DEF);
                default: host(8'($urandom));
            endcase
        else if (r < 60)
            tick();
        else if (r < 95)
            push(3'($urandom_range(5)), 8'($urandom));
        else
            send_word($urandom_range(1) ? 2'd3 : CMD_PUSH, 8'($urandom),
                      $urandom_range(1) ? 3'd6 : 3'd7, 8'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        out_stall = 1'b0;
        no_gaps = 1'b0;
        idle_cycles = 0;
        cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: self test, commands, arguments, queue and repeat corners
        tick();
        host(B_ECHO);
        host(B_RSND);
        host(B_RDID);
        tick();
        tick();
        host(B_LEDS);
        host(8'hFF);
        host(B_TYPM);
        host(8'h00);
        host(B_SCAN);
        host(8'h00);
        tick();
        host(B_SCAN);
        host(8'h03);
        host(B_TYPM);
        tick();
        host(8'h7F);
        host(B_DEF);
        host(8'h00);
        push(PK_DATA, 8'h00);
        push(PK_SPLIT, 8'd0);
        push(3'd6, 8'hFF);
        tick();
        tick();
        host(B_RESET);
        tick();
        drain();

        // full queue and full repeat buffer
        push(PK_START, 8'd0);
        for (int i = 0; i < 18; i++)
            push(PK_DATA, 8'(8'h10 + i));
        push(PK_END, 8'd0);
        for (int i = 0; i < 20; i++)
            tick();
        drain();

        // long repeat with no gaps at fast rate
        no_gaps = 1'b1;
        host(B_TYPM);
        host(8'h00);
        push(PK_START, 8'd0);
        push(PK_DATA, 8'hE0);
        push(PK_DATA, 8'h75);
        push(PK_END, 8'd0);
        for (int i = 0; i < 140; i++)
            tick();
        push(PK_STOP, 8'd0);
        tick();
        no_gaps = 1'b0;
        drain();

        for (int i = 0; i < 670; )
        begin
            if ($urandom_range(2) == 0)
            begin
                random_item();
                i++;
            end
            else
            begin
                key_sequence();
                i += 30;
            end
            if ($urandom_range(60) == 0)
                drain();
        end

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

/* sim.f */
+incdir+sv
sv/pkd_pkg.sv
sv/pkd_front.sv
sv/pkd_engine.sv
sv/ps2_keyboard_device_link.sv
bench/ps2_link_checker.sv
bench/testbench.sv
